// ===== hdl/dmr_cach_pkg.sv =====
// dmr_cach_pkg: shared types, constants and the short-lc interleave for the
// cach burst generator. No dependencies.
`default_nettype none

package dmr_cach_pkg;

	localparam int LC_BITS     = 68;
	localparam int STORE_BITS  = 96;
	localparam int STORE_BYTES = 12;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_LW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [4:0] COUNT_MAX     = 5'd31;
	localparam logic [4:0] STARTUP_RESET = 5'd20;
	localparam logic [3:0] OFFSET_STEP   = 4'd3;
	localparam logic [3:0] OFFSET_LAST   = 4'd9;
	localparam logic [3:0] OFFSET_WRAP   = 4'd12;

	typedef enum logic [1:0] {
		REQ_EMIT    = 2'd0,
		REQ_LOAD    = 2'd1,
		REQ_RESTART = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        tx_slot;
		logic        slot1_pending;
		logic        slot2_pending;
		logic [3:0]  lc_head;
		logic [63:0] lc_tail;
	} req_t;

	typedef struct packed {
		logic [23:0] cach_word;
		logic        sync_mark;
	} rsp_t;

	// one classified request as it sits in the queue
	typedef struct packed {
		op_t                   op;
		logic                  tx_slot;
		logic                  p1;
		logic                  p2;
		logic [STORE_BITS-1:0] lc;
	} cmd_t;

	typedef struct packed {
		logic [QUEUE_LW-1:0] level;
	} queue_status_t;

	typedef struct packed {
		logic [3:0] offset;
		logic [4:0] count;
	} back_status_t;

	// store bit position of each lc bit, counted msb first from byte 0
	localparam logic [6:0] LC_POS [LC_BITS] = '{
		7'd1,  7'd2,  7'd3,  7'd5,  7'd6,  7'd7,  7'd9,  7'd10, 7'd11, 7'd13,
		7'd15, 7'd16, 7'd17, 7'd19, 7'd20, 7'd21, 7'd23, 7'd25, 7'd26, 7'd27,
		7'd29, 7'd30, 7'd31, 7'd33, 7'd34, 7'd35, 7'd37, 7'd39, 7'd40, 7'd41,
		7'd43, 7'd44, 7'd45, 7'd47, 7'd49, 7'd50, 7'd51, 7'd53, 7'd54, 7'd55,
		7'd57, 7'd58, 7'd59, 7'd61, 7'd63, 7'd64, 7'd65, 7'd67, 7'd68, 7'd69,
		7'd71, 7'd73, 7'd74, 7'd75, 7'd77, 7'd78, 7'd79, 7'd81, 7'd82, 7'd83,
		7'd85, 7'd87, 7'd88, 7'd89, 7'd91, 7'd92, 7'd93, 7'd95
	};

	// pure wiring: lc bit i lands on store bit (95 - position)
	function automatic logic [STORE_BITS-1:0] interleave(input logic [3:0] head,
			input logic [63:0] tail);
		logic [LC_BITS-1:0]    lc;
		logic [STORE_BITS-1:0] st;
		lc = {head, tail};
		st = '0;
		for (int i = 0; i < LC_BITS; i++) begin
			st[STORE_BITS - 1 - int'(LC_POS[i])] = lc[LC_BITS - 1 - i];
		end
		return st;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/dmr_cach_front.sv =====
// dmr_cach_front: accepts requests, drops unknown types and builds the
// interleaved lc for loads. Depends on dmr_cach_pkg.
`default_nettype none

module dmr_cach_front (
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  dmr_cach_pkg::req_t     req,
	input  wire logic              queue_full,
	output logic                   push,
	output dmr_cach_pkg::cmd_t     push_cmd
);

	logic known;

	always_comb begin
		case (dmr_cach_pkg::op_t'(req.req_type))
			dmr_cach_pkg::REQ_EMIT,
			dmr_cach_pkg::REQ_LOAD,
			dmr_cach_pkg::REQ_RESTART: known = 1'b1;
			default:                   known = 1'b0;
		endcase
	end

	// unknown types are taken and dropped without using a queue slot
	assign req_stall = queue_full;
	assign push      = req_valid && !queue_full && known;

	always_comb begin
		push_cmd.op      = dmr_cach_pkg::op_t'(req.req_type);
		push_cmd.tx_slot = req.tx_slot;
		push_cmd.p1      = req.slot1_pending;
		push_cmd.p2      = req.slot2_pending;
		push_cmd.lc      = dmr_cach_pkg::interleave(req.lc_head, req.lc_tail);
	end

endmodule

`default_nettype wire

// ===== hdl/dmr_cach_queue.sv =====
// dmr_cach_queue: small command fifo between front and back.
// Depends on dmr_cach_pkg.
`default_nettype none

module dmr_cach_queue (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  dmr_cach_pkg::cmd_t           push_cmd,
	input  wire logic                    pop,
	output logic                         head_valid,
	output dmr_cach_pkg::cmd_t           head_cmd,
	output logic                         full,
	output dmr_cach_pkg::queue_status_t  status
);

	dmr_cach_pkg::cmd_t                     entry_q [dmr_cach_pkg::QUEUE_DEPTH];
	logic [dmr_cach_pkg::QUEUE_AW-1:0]      wr_ptr_q;
	logic [dmr_cach_pkg::QUEUE_AW-1:0]      rd_ptr_q;
	logic [dmr_cach_pkg::QUEUE_LW-1:0]      level_q;

	localparam logic [dmr_cach_pkg::QUEUE_LW-1:0] LEVEL_FULL =
		dmr_cach_pkg::QUEUE_LW'(dmr_cach_pkg::QUEUE_DEPTH);
	localparam logic [dmr_cach_pkg::QUEUE_AW-1:0] PTR_LAST =
		dmr_cach_pkg::QUEUE_AW'(dmr_cach_pkg::QUEUE_DEPTH - 1);

	assign head_valid   = level_q != '0;
	assign head_cmd     = entry_q[rd_ptr_q];
	assign full         = level_q == LEVEL_FULL;
	assign status.level = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/dmr_cach_back.sv =====
// dmr_cach_back: executes queued commands, holds the lc stores and counters
// and drives the burst output register. Depends on dmr_cach_pkg.
`default_nettype none

module dmr_cach_back (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    head_valid,
	input  dmr_cach_pkg::cmd_t           head_cmd,
	output logic                         pop,
	input  wire logic [4:0]              startup_frames,
	output logic                         rsp_valid,
	input  wire logic                    rsp_stall,
	output dmr_cach_pkg::rsp_t           rsp,
	output dmr_cach_pkg::back_status_t   status
);

	localparam int EXT_BITS = dmr_cach_pkg::STORE_BITS + 24;

	logic [3:0]                          offset_q;
	logic [4:0]                          count_q;
	logic [dmr_cach_pkg::STORE_BITS-1:0] pending_q;
	logic [dmr_cach_pkg::STORE_BITS-1:0] active_q;
	logic                                rsp_valid_q;
	dmr_cach_pkg::rsp_t                  rsp_q;

	logic                                out_free;
	logic                                is_emit;
	logic [4:0]                          count_n;
	logic [3:0]                          off;
	logic [dmr_cach_pkg::STORE_BITS-1:0] active_n;
	logic [EXT_BITS-1:0]                 ext;
	logic [6:0]                          top_bit;
	logic [23:0]                         slice;
	logic                                at, tc, ls1, ls0, h0, h1, h2;
	logic [23:0]                         word;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign is_emit  = head_cmd.op == dmr_cach_pkg::REQ_EMIT;
	assign pop      = head_valid && (!is_emit || out_free);

	always_comb begin
		count_n  = (count_q < dmr_cach_pkg::COUNT_MAX) ? count_q + 5'd1 : count_q;
		off      = (offset_q >= dmr_cach_pkg::OFFSET_WRAP) ? 4'd0 : offset_q;
		// superframe start takes the pending lc, or zeros when both slots idle
		if (off == 4'd0) begin
			active_n = (head_cmd.p1 || head_cmd.p2) ? pending_q : '0;
		end else begin
			active_n = active_q;
		end
		// bytes past the store read as zero
		ext     = {active_n, 24'd0};
		top_bit = 7'(EXT_BITS - 1) - {off, 3'b000};
		slice   = ext[top_bit -: 24];

		tc  = head_cmd.tx_slot;
		at  = (count_n >= startup_frames) &&
			(head_cmd.tx_slot ? head_cmd.p1 : head_cmd.p2);
		ls1 = off != 4'd0;
		ls0 = off != dmr_cach_pkg::OFFSET_LAST;
		h0  = at ^ tc ^ ls1;
		h1  = tc ^ ls1 ^ ls0;
		h2  = at ^ tc ^ ls0;

		word     = slice;
		word[23] = word[23] | at;
		word[19] = word[19] | tc;
		word[15] = word[15] | ls1;
		word[11] = word[11] | ls0;
		word[9]  = word[9]  | h0;
		word[5]  = word[5]  | h1;
		word[1]  = word[1]  | h2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			count_q     <= '0;
			pending_q   <= '0;
			active_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= (pop && is_emit) || (rsp_valid_q && rsp_stall);
			if (pop) begin
				case (head_cmd.op)
					dmr_cach_pkg::REQ_EMIT: begin
						count_q  <= count_n;
						active_q <= active_n;
						offset_q <= off + dmr_cach_pkg::OFFSET_STEP;
					end
					dmr_cach_pkg::REQ_LOAD: begin
						pending_q <= head_cmd.lc;
					end
					dmr_cach_pkg::REQ_RESTART: begin
						count_q <= '0;
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_emit) begin
			rsp_q.cach_word <= word;
			rsp_q.sync_mark <= head_cmd.tx_slot;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;
	assign status.offset = offset_q;
	assign status.count  = count_q;

endmodule

`default_nettype wire

// ===== hdl/dmr_cach_burst_generator.sv =====
// dmr_cach_burst_generator: top level, front, command queue, back and the
// startup register. Depends on dmr_cach_pkg, dmr_cach_front, dmr_cach_queue,
// dmr_cach_back.
//
// channel   signals                      dir  notes
// request   req_valid, req_stall, req    in   accepted when valid and not stall
// burst     rsp_valid, rsp_stall, rsp    out  one per emit request
// config    cfg_we, cfg_data             in   startup_frames, no read-back
//
// one request per cycle sustained while req_stall is low; an emit reaches rsp by
// way of the queue entry register, then the back stage output register.
// the four-entry queue decouples input from the output register: req_stall
// rises only when the queue is full, so loads and restarts keep draining while
// a burst waits on rsp_stall. reset clears all but entry_q and rsp_q, no sweep.
`default_nettype none

module dmr_cach_burst_generator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  dmr_cach_pkg::req_t      req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output dmr_cach_pkg::rsp_t      rsp,
	input  wire logic               cfg_we,
	input  wire logic [4:0]         cfg_data
);

	logic                         push;
	dmr_cach_pkg::cmd_t           push_cmd;
	logic                         pop;
	logic                         head_valid;
	dmr_cach_pkg::cmd_t           head_cmd;
	logic                         queue_full;
	dmr_cach_pkg::queue_status_t  queue_status;
	dmr_cach_pkg::back_status_t   back_status;
	logic [4:0]                   startup_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_q <= dmr_cach_pkg::STARTUP_RESET;
		end else if (cfg_we) begin
			startup_q <= cfg_data;
		end
	end

	dmr_cach_front u_front (
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	dmr_cach_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.full       (queue_full),
		.status     (queue_status)
	);

	dmr_cach_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_cmd       (head_cmd),
		.pop            (pop),
		.startup_frames (startup_q),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp),
		.status         (back_status)
	);

	// burst offset only ever sits on a slice boundary
	a_offset_legal: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.offset == 4'd0 || back_status.offset == 4'd3 ||
		back_status.offset == 4'd6 || back_status.offset == 4'd9 ||
		back_status.offset == dmr_cach_pkg::OFFSET_WRAP)
		else $error("burst offset off a slice boundary");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		queue_status.level <= dmr_cach_pkg::QUEUE_LW'(dmr_cach_pkg::QUEUE_DEPTH))
		else $error("command queue overfilled");

	// a burst leaves only when taken
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rsp_valid) |-> $past(!rsp_stall))
		else $error("burst dropped while stalled");

	// counter saturates and leaves its ceiling only through a restart
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		$past(back_status.count) == dmr_cach_pkg::COUNT_MAX && back_status.count != '0
		|-> back_status.count == dmr_cach_pkg::COUNT_MAX)
		else $error("burst counter left saturation without restart");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench for dmr_cach_burst_generator: a scoreboard class predicts every cach burst
// from accepted requests; tasks drive requests and the startup register, burst_sink stalls.
// Depends on dmr_cach_pkg and the dmr_cach_burst_generator rtl.

module testbench;

	localparam logic [1:0] REQ_EMIT = dmr_cach_pkg::REQ_EMIT;
	localparam logic [1:0] REQ_LOAD = dmr_cach_pkg::REQ_LOAD;
	localparam logic [1:0] REQ_RESTART = dmr_cach_pkg::REQ_RESTART;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [4:0] TALLY_TOP = 5'd31;
	localparam logic [4:0] STARTUP_AFTER_RESET = 5'd20;
	localparam int STORE_W = 96;
	localparam int LC_W = 68;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX = 10;

	class burst_scoreboard;
		logic [4:0] access_hold;
		logic [3:0] slice_offset;
		logic [4:0] burst_tally;
		logic [STORE_W-1:0] staged_lc;
		logic [STORE_W-1:0] live_lc;
		dmr_cach_pkg::rsp_t expected_bursts[$];
		int mismatches;

		function new();
			access_hold = STARTUP_AFTER_RESET;
			slice_offset = '0;
			burst_tally = '0;
			staged_lc = '0;
			live_lc = '0;
			mismatches = 0;
		endfunction

		function void set_startup(logic [4:0] value);
			access_hold = value;
		endfunction

		// tact and parity positions repeat in every 24-bit burst
		function bit is_tact_bit(int pos);
			int q;
			q = pos % 24;
			return q == 0 || q == 4 || q == 8 || q == 12 || q == 14 || q == 18 || q == 22;
		endfunction

		// lc bits fill the free store positions in order, msb first from byte 0
		function logic [STORE_W-1:0] spread_short_lc(logic [3:0] head, logic [63:0] tail);
			logic [LC_W-1:0] lc;
			logic [STORE_W-1:0] st;
			int n;
			lc = {head, tail};
			st = '0;
			n = 0;
			for (int p = 0; p < STORE_W; p++) begin
				if (!is_tact_bit(p)) begin
					st[STORE_W - 1 - p] = lc[LC_W - 1 - n];
					n++;
				end
			end
			return st;
		endfunction

		function void note_request(dmr_cach_pkg::req_t r);
			logic [23:0] w;
			logic at, tc, ls1, ls0;
			dmr_cach_pkg::rsp_t e;
			case (r.req_type)
				REQ_LOAD: staged_lc = spread_short_lc(r.lc_head, r.lc_tail);
				REQ_RESTART: burst_tally = '0;
				REQ_EMIT: begin
					if (burst_tally != TALLY_TOP)
						burst_tally = burst_tally + 5'd1;
					if (slice_offset >= 4'd12)
						slice_offset = '0;
					if (slice_offset == 4'd0)
						live_lc = (r.slot1_pending || r.slot2_pending) ? staged_lc : '0;
					w = live_lc[STORE_W - 1 - 8 * int'(slice_offset) -: 24];
					// access slot is the one not following this burst
					at = (burst_tally >= access_hold) &&
						(r.tx_slot ? r.slot1_pending : r.slot2_pending);
					tc = r.tx_slot;
					ls1 = slice_offset != 4'd0;
					ls0 = slice_offset != 4'd9;
					w[23] = w[23] | at;
					w[19] = w[19] | tc;
					w[15] = w[15] | ls1;
					w[11] = w[11] | ls0;
					w[9] = w[9] | (at ^ tc ^ ls1);
					w[5] = w[5] | (tc ^ ls1 ^ ls0);
					w[1] = w[1] | (at ^ tc ^ ls0);
					slice_offset = slice_offset + 4'd3;
					e.cach_word = w;
					e.sync_mark = r.tx_slot;
					expected_bursts.push_back(e);
				end
				default: ;
			endcase
		endfunction

		function void note_mismatch(string field, logic [23:0] want, logic [23:0] got);
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("burst mismatch on %s: expected %06h, got %06h", field, want, got);
		endfunction

		function void check_burst(dmr_cach_pkg::rsp_t got);
			dmr_cach_pkg::rsp_t want;
			if (expected_bursts.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("burst with none expected: cach_word %06h sync_mark %0b",
						got.cach_word, got.sync_mark);
				return;
			end
			want = expected_bursts.pop_front();
			if (got.cach_word !== want.cach_word)
				note_mismatch("cach_word", want.cach_word, got.cach_word);
			if (got.sync_mark !== want.sync_mark)
				note_mismatch("sync_mark", 24'(want.sync_mark), 24'(got.sync_mark));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	dmr_cach_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	dmr_cach_pkg::rsp_t rsp;
	logic cfg_we;
	logic [4:0] cfg_data;

	burst_scoreboard sb;
	bit idle_enable;
	bit long_hold_req;
	int cycle_count = 0;

	dmr_cach_burst_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_burst(rsp);
	end

	// burst side stall: short random bursts, one long hold on request
	initial begin : burst_sink
		int stall_left;
		stall_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && idle_enable && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 5);
			end
			if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic dmr_cach_pkg::req_t make_req(logic [1:0] kind, logic tx, logic p1,
			logic p2, logic [3:0] head, logic [63:0] tail);
		dmr_cach_pkg::req_t r;
		r.req_type = kind;
		r.tx_slot = tx;
		r.slot1_pending = p1;
		r.slot2_pending = p2;
		r.lc_head = head;
		r.lc_tail = tail;
		return r;
	endfunction

	function automatic dmr_cach_pkg::req_t random_req(logic [1:0] kind);
		return make_req(kind, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), {$urandom(), $urandom()});
	endfunction

	// called at a rising edge; returns at the edge that accepts the request
	task automatic push_request(input dmr_cach_pkg::req_t r);
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(r);
	endtask

	// loads and restarts may still sit in the queue after the last burst
	task automatic drain_pipeline();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_bursts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_startup(input logic [4:0] value);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_startup(value);
	endtask

	// mostly whole superframes, some restarts and some noise
	task automatic run_traffic(input int n);
		int sent;
		int pick;
		logic [1:0] kind;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if ($urandom_range(0, 1) == 1) begin
					push_request(random_req(REQ_LOAD));
					sent++;
				end
				repeat (4) begin
					push_request(random_req(REQ_EMIT));
					sent++;
				end
			end else if (pick < 76) begin
				push_request(random_req(REQ_RESTART));
				sent++;
			end else begin
				kind = 2'($urandom_range(0, 3));
				push_request(random_req(kind));
				if (kind != REQ_UNUSED)
					sent++;
			end
		end
	endtask

	initial begin
		logic [4:0] startup_value;
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		idle_enable = 1'b1;
		long_hold_req = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_startup(5'd0);
		push_request(make_req(REQ_EMIT, 1'b0, 1'b1, 1'b1, 4'h0, 64'h0));
		push_request(make_req(REQ_LOAD, 1'b0, 1'b0, 1'b0, 4'hF, '1));
		push_request(make_req(REQ_EMIT, 1'b1, 1'b0, 1'b0, 4'h0, 64'h0));
		push_request(make_req(REQ_EMIT, 1'b0, 1'b0, 1'b1, 4'h0, 64'h0));
		push_request(make_req(REQ_EMIT, 1'b1, 1'b1, 1'b0, 4'h0, 64'h0));
		// superframe start picks up the all-ones lc
		push_request(make_req(REQ_EMIT, 1'b0, 1'b1, 1'b0, 4'hF, '1));
		push_request(make_req(REQ_EMIT, 1'b1, 1'b0, 1'b1, 4'hF, '1));
		push_request(make_req(REQ_EMIT, 1'b0, 1'b1, 1'b1, 4'h0, 64'h0));
		push_request(make_req(REQ_EMIT, 1'b1, 1'b1, 1'b1, 4'h0, 64'h0));
		push_request(make_req(REQ_LOAD, 1'b1, 1'b1, 1'b1, 4'hA, 64'h5555_5555_5555_5555));
		push_request(make_req(REQ_LOAD, 1'b0, 1'b0, 1'b0, 4'h5, 64'hAAAA_AAAA_AAAA_AAAA));
		// nothing pending on either slot: zeros go out instead
		push_request(make_req(REQ_EMIT, 1'b1, 1'b0, 1'b0, 4'h0, 64'h0));
		push_request(make_req(REQ_EMIT, 1'b0, 1'b1, 1'b1, 4'h0, 64'h0));
		push_request(make_req(REQ_EMIT, 1'b1, 1'b1, 1'b1, 4'h0, 64'h0));
		push_request(make_req(REQ_EMIT, 1'b0, 1'b1, 1'b1, 4'h0, 64'h0));
		push_request(make_req(REQ_EMIT, 1'b0, 1'b1, 1'b1, 4'h0, 64'h0));
		push_request(make_req(REQ_RESTART, 1'b1, 1'b1, 1'b1, 4'hF, '1));
		push_request(make_req(REQ_UNUSED, 1'b1, 1'b1, 1'b1, 4'hF, '1));
		push_request(make_req(REQ_EMIT, 1'b1, 1'b1, 1'b0, 4'h0, 64'h0));
		push_request(make_req(REQ_EMIT, 1'b0, 1'b0, 1'b1, 4'h0, 64'h0));
		push_request(make_req(REQ_EMIT, 1'b1, 1'b1, 1'b1, 4'h0, 64'h0));
		push_request(make_req(REQ_LOAD, 1'b0, 1'b0, 1'b0, 4'h0, 64'h0));
		push_request(make_req(REQ_EMIT, 1'b0, 1'b1, 1'b1, 4'h0, 64'h0));
		drain_pipeline();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0, 6: startup_value = TALLY_TOP;
				1: startup_value = 5'd5;
				2: startup_value = 5'd0;
				3: startup_value = STARTUP_AFTER_RESET;
				5: startup_value = 5'd1;
				default: startup_value = 5'($urandom_range(0, 31));
			endcase
			if (phase == PHASES - 1)
				idle_enable = 1'b0;
			write_startup(startup_value);
			// burst side holds off while requests keep coming, filling the queue
			if (phase == 2)
				long_hold_req = 1'b1;
			run_traffic(ITEMS_PER_PHASE);
			drain_pipeline();
		end

		if (sb.mismatches == 0 && sb.expected_bursts.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
